[rtl/cdmh_pkg.sv]
// Shared types, constants and helper functions for the CPU deadline max-heap.
// Used by cdmh_slot_ram and cpu_deadline_max_heap_core; no dependencies.
package cdmh_pkg;

  localparam int MaxCpus = 16;
  localparam int CpuW    = 4;
  localparam int SlotW   = 4;
  localparam int CntW    = 5;
  localparam int DlW     = 64;
  localparam int MaskW   = 16;

  localparam logic signed [4:0] CpuNone = -5'sd1;

  localparam logic FuncSet  = 1'b0;
  localparam logic FuncFind = 1'b1;

  localparam logic CfgPresent = 1'b0;
  localparam logic CfgActive  = 1'b1;

  typedef struct packed {
    logic [CpuW-1:0] cpu;
    logic [DlW-1:0]  dl;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    entry_t           data;
  } slot_wr_t;

  typedef struct packed {
    logic             re;
    logic [SlotW-1:0] addr;
  } slot_rd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_UPD,
    ST_REM,
    ST_SD_L,
    ST_SD_LW,
    ST_SD_RW,
    ST_SU,
    ST_SU_W,
    ST_WR,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_e;

  // wrapping order: a is before b when a-b is negative
  function automatic logic before_f(logic [DlW-1:0] a, logic [DlW-1:0] b);
    logic [DlW-1:0] diff;
    diff = a - b;
    return diff[DlW-1];
  endfunction

  function automatic logic ordered_f(logic [DlW-1:0] a, logic [DlW-1:0] b, logic plain);
    logic r;
    r = plain ? (a <= b) : before_f(a, b);
    return r;
  endfunction

  function automatic logic signed [4:0] lowest_f(logic [MaskW-1:0] v);
    logic signed [4:0] r;
    r = CpuNone;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic signed [4:0] limit_f(logic signed [4:0] c, logic [CntW-1:0] present);
    logic signed [4:0] r;
    r = c;
    if (c[4] || (c >= present)) r = CpuNone;
    return r;
  endfunction

endpackage

[rtl/cpu_deadline_max_heap_core.sv]
// Top level of the CPU deadline max-heap: sequencer, CPU-to-slot map,
// free mask and result registers. Depends on cdmh_pkg and cdmh_slot_ram.
//
// Usage: drive the word on the input ports with start high. It is taken at
// a rising edge where start is high and busy is low. busy stays high until
// the result is out and drops in the cycle done_o is high. Each word gives
// exactly one result, shown on the result ports for one cycle with done_o
// high. The receiver cannot stall it.
// Configuration (present_cpus index 0, active_mask index 1) goes over the
// cfg channel, which is always ready. Write it only while the block is idle.
// A find passes FIN1, FIN2 and FIN3 before done_o rises. A set passes MAP,
// UPD or REM as needed, any sift (SU and SU_W per level up; SD_L, SD_LW and
// SD_RW per level down, SD_RW skipped with no right child), then FIN1 to
// FIN3. The longest case is a sift down over four levels at 16 CPUs. The
// heap walk is bounded by the single read port of the slot memory. A new
// word can be taken in the cycle done_o is high.
// Reset empties the heap, marks all CPUs free and restores present_cpus to
// 16 and active_mask to all ones; no clearing pass is needed.
module cpu_deadline_max_heap_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func_i,
  input  logic [3:0]              cpu_i,
  input  logic [63:0]             deadline_i,
  input  logic                    stolen_i,
  input  logic                    valid_req_i,
  input  logic [63:0]             task_deadline_i,
  input  logic [15:0]             allowed_mask_i,
  input  logic                    use_mask_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output logic                    done_o,
  output logic signed [4:0]       chosen_cpu_o,
  output logic [15:0]             pick_mask_o,
  output logic signed [4:0]       latest_cpu_o,
  output logic signed [4:0]       earliest_cpu_o,
  output logic signed [4:0]       idle_cpu_o,
  output logic signed [4:0]       stealable_cpu_o,
  output logic [4:0]              heap_count_o
);

  cdmh_pkg::state_e state_q, state_d;

  logic [4:0]  present_q;
  logic [15:0] active_q;
  logic [15:0] free_q, free_d;
  logic [4:0]  size_q, size_d;

  logic        func_q, stolen_q, valid_q, use_q;
  logic [3:0]  cpu_q;
  logic [63:0] dl_q, tdl_q;
  logic [15:0] allowed_q;

  logic [3:0]        idx_q, idx_d;
  cdmh_pkg::entry_t  cur_q, cur_d;
  cdmh_pkg::entry_t  cand_q, cand_d;
  logic [3:0]        cand_idx_q, cand_idx_d;
  logic              cand_mv_q, cand_mv_d;
  logic              plain_q, plain_d;
  logic [3:0]        old_q, old_d;
  cdmh_pkg::entry_t  top_q, top_d;

  // CPU-to-slot map; an entry is meaningful only while its CPU is not free
  logic [3:0] map_mem [cdmh_pkg::MaxCpus];
  logic [3:0] map_rd_q;
  logic       map_we;
  logic [3:0] map_wa, map_wd;

  cdmh_pkg::slot_wr_t slot_wr;
  cdmh_pkg::slot_rd_t slot_rd;
  cdmh_pkg::entry_t   slot_q;

  logic              out_load;
  logic signed [4:0] best_d, latest_d, earliest_d, idle_d, steal_d;
  logic [15:0]       lmask_d;

  cdmh_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_i      (slot_rd),
    .rd_data_o (slot_q)
  );

  assign busy        = (state_q != cdmh_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (start && !busy) map_rd_q <= map_mem[cpu_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cdmh_pkg::ST_IDLE;
      present_q <= 5'd16;
      active_q  <= '1;
      free_q    <= '1;
      size_q    <= '0;
      done_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      size_q  <= size_d;
      done_o  <= out_load;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cdmh_pkg::CfgPresent: present_q <= cfg_data_i[4:0];
          cdmh_pkg::CfgActive:  active_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q    <= func_i;
      cpu_q     <= cpu_i;
      dl_q      <= deadline_i;
      stolen_q  <= stolen_i;
      valid_q   <= valid_req_i;
      tdl_q     <= task_deadline_i;
      allowed_q <= allowed_mask_i;
      use_q     <= use_mask_i;
    end
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
    cand_mv_q  <= cand_mv_d;
    plain_q    <= plain_d;
    old_q      <= old_d;
    top_q      <= top_d;
    if (out_load) begin
      chosen_cpu_o     <= best_d;
      pick_mask_o      <= lmask_d;
      latest_cpu_o     <= latest_d;
      earliest_cpu_o   <= earliest_d;
      idle_cpu_o       <= idle_d;
      stealable_cpu_o  <= steal_d;
      heap_count_o     <= size_q;
    end
  end

  always_comb begin
    logic [5:0]       lft, rgt, sz6;
    logic             old_vld;
    cdmh_pkg::entry_t dec_ent;
    logic [3:0]       dec_idx;
    logic             dec_mv, dec_go;
    logic [15:0]      cand_m, busy_m, hi_m;
    logic signed [4:0] s1;

    state_d    = state_q;
    free_d     = free_q;
    size_d     = size_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    cand_d     = cand_q;
    cand_idx_d = cand_idx_q;
    cand_mv_d  = cand_mv_q;
    plain_d    = plain_q;
    old_d      = old_q;
    top_d      = top_q;
    slot_wr    = '0;
    slot_rd    = '0;
    map_we     = 1'b0;
    map_wa     = '0;
    map_wd     = '0;
    out_load   = 1'b0;

    lft     = {1'b0, idx_q, 1'b1};
    rgt     = lft + 6'd1;
    sz6     = {1'b0, size_q};
    old_vld = !free_q[cpu_q];
    dec_ent = cur_q;
    dec_idx = idx_q;
    dec_mv  = 1'b0;
    dec_go  = 1'b0;

    case (state_q)
      cdmh_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (func_i == cdmh_pkg::FuncFind) ? cdmh_pkg::ST_FIN1 : cdmh_pkg::ST_MAP;
        end
      end
      cdmh_pkg::ST_MAP: begin
        old_d   = map_rd_q;
        cur_d   = '{cpu: cpu_q, dl: dl_q};
        plain_d = stolen_q;
        if (!valid_q) begin
          if (!old_vld || size_q == '0) begin
            state_d = cdmh_pkg::ST_FIN1;
          end else begin
            slot_rd = '{re: 1'b1, addr: 4'(size_q - 5'd1)};
            state_d = cdmh_pkg::ST_REM;
          end
        end else if (!old_vld) begin
          if (size_q >= 5'(cdmh_pkg::MaxCpus)) begin
            state_d = cdmh_pkg::ST_FIN1;
          end else begin
            free_d[cpu_q] = 1'b0;
            size_d = size_q + 5'd1;
            idx_d  = size_q[3:0];
            // new slot starts at deadline zero
            if (cdmh_pkg::before_f(dl_q, '0)) begin
              plain_d = 1'b0;
              state_d = cdmh_pkg::ST_SD_L;
            end else begin
              state_d = cdmh_pkg::ST_SU;
            end
          end
        end else begin
          slot_rd = '{re: 1'b1, addr: map_rd_q};
          state_d = cdmh_pkg::ST_UPD;
        end
      end
      cdmh_pkg::ST_UPD: begin
        idx_d = old_q;
        if (slot_q.dl == dl_q) begin
          state_d = cdmh_pkg::ST_FIN1;
        end else if (cdmh_pkg::before_f(dl_q, slot_q.dl)) begin
          plain_d = 1'b0;
          state_d = cdmh_pkg::ST_SD_L;
        end else begin
          state_d = cdmh_pkg::ST_SU;
        end
      end
      cdmh_pkg::ST_REM: begin
        size_d        = size_q - 5'd1;
        free_d[cpu_q] = 1'b1;
        if (slot_q.cpu != cpu_q) begin
          cur_d   = slot_q;
          idx_d   = old_q;
          plain_d = 1'b1;
          state_d = cdmh_pkg::ST_SD_L;
        end else begin
          state_d = cdmh_pkg::ST_FIN1;
        end
      end
      cdmh_pkg::ST_SD_L: begin
        if (lft < sz6) begin
          slot_rd = '{re: 1'b1, addr: lft[3:0]};
          state_d = cdmh_pkg::ST_SD_LW;
        end else begin
          state_d = cdmh_pkg::ST_WR;
        end
      end
      cdmh_pkg::ST_SD_LW: begin
        if (cdmh_pkg::ordered_f(cur_q.dl, slot_q.dl, plain_q)) begin
          dec_ent = slot_q;
          dec_idx = lft[3:0];
          dec_mv  = 1'b1;
        end
        cand_d     = dec_ent;
        cand_idx_d = dec_idx;
        cand_mv_d  = dec_mv;
        if (rgt < sz6) begin
          slot_rd = '{re: 1'b1, addr: rgt[3:0]};
          state_d = cdmh_pkg::ST_SD_RW;
        end else begin
          dec_go = 1'b1;
        end
      end
      cdmh_pkg::ST_SD_RW: begin
        dec_ent = cand_q;
        dec_idx = cand_idx_q;
        dec_mv  = cand_mv_q;
        if (cdmh_pkg::ordered_f(cand_q.dl, slot_q.dl, plain_q)) begin
          dec_ent = slot_q;
          dec_idx = rgt[3:0];
          dec_mv  = 1'b1;
        end
        dec_go = 1'b1;
      end
      cdmh_pkg::ST_SU: begin
        if (idx_q == '0) begin
          state_d = cdmh_pkg::ST_WR;
        end else begin
          slot_rd = '{re: 1'b1, addr: 4'((idx_q - 4'd1) >> 1)};
          state_d = cdmh_pkg::ST_SU_W;
        end
      end
      cdmh_pkg::ST_SU_W: begin
        if (cdmh_pkg::ordered_f(slot_q.dl, cur_q.dl, plain_q)) begin
          slot_wr = '{we: 1'b1, addr: idx_q, data: slot_q};
          map_we  = 1'b1;
          map_wa  = slot_q.cpu;
          map_wd  = idx_q;
          idx_d   = 4'((idx_q - 4'd1) >> 1);
          state_d = cdmh_pkg::ST_SU;
        end else begin
          state_d = cdmh_pkg::ST_WR;
        end
      end
      cdmh_pkg::ST_WR: begin
        // moving entry lands in its final slot
        slot_wr = '{we: 1'b1, addr: idx_q, data: cur_q};
        map_we  = 1'b1;
        map_wa  = cur_q.cpu;
        map_wd  = idx_q;
        state_d = cdmh_pkg::ST_FIN1;
      end
      cdmh_pkg::ST_FIN1: begin
        slot_rd = '{re: 1'b1, addr: '0};
        state_d = cdmh_pkg::ST_FIN2;
      end
      cdmh_pkg::ST_FIN2: begin
        top_d   = slot_q;
        slot_rd = '{re: 1'b1, addr: 4'(size_q - 5'd1)};
        state_d = cdmh_pkg::ST_FIN3;
      end
      cdmh_pkg::ST_FIN3: begin
        out_load = 1'b1;
        state_d  = cdmh_pkg::ST_IDLE;
      end
      default: state_d = cdmh_pkg::ST_IDLE;
    endcase

    if (dec_go) begin
      if (dec_mv) begin
        slot_wr = '{we: 1'b1, addr: idx_q, data: dec_ent};
        map_we  = 1'b1;
        map_wa  = dec_ent.cpu;
        map_wd  = idx_q;
        idx_d   = dec_idx;
        state_d = cdmh_pkg::ST_SD_L;
      end else begin
        state_d = cdmh_pkg::ST_WR;
      end
    end

    // result word, taken from state after the update
    cand_m  = free_q & allowed_q & active_q;
    best_d  = cdmh_pkg::CpuNone;
    lmask_d = '0;
    if (func_q == cdmh_pkg::FuncFind) begin
      if (use_q && cand_m != '0) begin
        lmask_d = cand_m;
        best_d  = cdmh_pkg::lowest_f(cand_m);
      end else if (size_q != '0 && allowed_q[top_q.cpu] &&
                   cdmh_pkg::before_f(tdl_q, top_q.dl)) begin
        best_d = {1'b0, top_q.cpu};
        if (use_q) lmask_d = 16'd1 << top_q.cpu;
      end
    end
    latest_d   = (size_q != '0) ? cdmh_pkg::limit_f({1'b0, top_q.cpu}, present_q)
                                : cdmh_pkg::CpuNone;
    earliest_d = (size_q != '0) ? cdmh_pkg::limit_f({1'b0, slot_q.cpu}, present_q)
                                : cdmh_pkg::CpuNone;
    idle_d     = cdmh_pkg::limit_f(cdmh_pkg::lowest_f(free_q), present_q);
    busy_m     = ~free_q;
    for (int i = 0; i < cdmh_pkg::MaskW; i++) begin
      hi_m[i] = busy_m[i] && (5'(i) > {1'b0, cpu_q});
    end
    s1      = cdmh_pkg::limit_f(cdmh_pkg::lowest_f(hi_m), present_q);
    steal_d = s1[4] ? cdmh_pkg::limit_f(cdmh_pkg::lowest_f(busy_m), present_q) : s1;
  end

  // heap size always matches the number of CPUs marked busy
  a_size_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'($countones(~free_q)) == size_q) else $error("heap size and free mask disagree");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy)) else $error("result outside a busy period");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> heap_count_o <= 5'(cdmh_pkg::MaxCpus)) else $error("heap count overflow");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not start work");

endmodule

[rtl/cdmh_slot_ram.sv]
// Heap slot storage: 16 entries of {cpu, deadline}, one write and one
// registered read port. Depends on cdmh_pkg.
module cdmh_slot_ram (
  input  logic               clk_i,
  input  cdmh_pkg::slot_wr_t wr_i,
  input  cdmh_pkg::slot_rd_t rd_i,
  output cdmh_pkg::entry_t   rd_data_o
);

  cdmh_pkg::entry_t mem [cdmh_pkg::MaxCpus];
  cdmh_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem[wr_i.addr] <= wr_i.data;
    if (rd_i.re) rd_data_q <= mem[rd_i.addr];
  end

  assign rd_data_o = rd_data_q;

endmodule
